>>> sv/gls_pkg.sv
// Shared constants, types and controller/datapath interface structs for grid_line_of_sight.
package gls_pkg;

  localparam int MAP_WIDTH  = 64;
  localparam int MAP_HEIGHT = 64;
  localparam int COL_W      = $clog2(MAP_WIDTH);
  localparam int ROW_W      = $clog2(MAP_HEIGHT);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WR,
    ST_STEP,
    ST_DIAG,
    ST_ADV,
    ST_MID,
    ST_AXIS,
    ST_MOVE,
    ST_PT_LD,
    ST_PT_EVAL,
    ST_PT_CHK,
    ST_RESULT
  } gls_state_t;

  // Which point of the current step is under test.
  typedef enum logic [1:0] {
    PH_DIAG,
    PH_MID,
    PH_AXA,
    PH_AXB
  } gls_phase_t;

  typedef struct packed {
    logic       ld_item;
    logic       wr_rd;
    logic       wr_wr;
    logic       f_add;
    logic       adv;
    logic       move;
    logic       pt_ld;
    gls_phase_t pt_sel;
    logic       pt_eval;
    logic       pt_next;
  } gls_cmd_t;

  typedef struct packed {
    logic at_end;
    logic f_ge;
    logic f_nz;
    logic dmin_z;
    logic pt_off;
    logic row_hit;
    logic row_last;
  } gls_status_t;

endpackage

>>> sv/grid_line_of_sight.sv
// Top level: obstacle map with line-of-sight queries.
//  channel | direction | beat contents
//  in_     | input     | command, cell_x/y, cell_blocked, start_x/y, end_x/y
//  out_    | output    | sight_clear (one beat per query, none per write)
// A write beat is latched, then its row is read and written back.
// A query walks up to 126 half-cell steps; each tested point is loaded, checked against
// the map bounds, then scanned one map row of its window at a time (up to 4).
// Reset is synchronous; per-row valid flags clear the map at once, no sweep.
// A finished result waits in the output register while the next beat is taken.
module grid_line_of_sight
  import gls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [5:0] in_cell_x,
  input  logic [5:0] in_cell_y,
  input  logic       in_cell_blocked,
  input  logic [5:0] in_start_x,
  input  logic [5:0] in_start_y,
  input  logic [5:0] in_end_x,
  input  logic [5:0] in_end_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_sight_clear
);

  gls_cmd_t    cmd;
  gls_status_t sts;

  gls_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_command      (in_command),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sight_clear (out_sight_clear),
    .sts             (sts),
    .cmd             (cmd)
  );

  gls_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_cell_x       (in_cell_x),
    .in_cell_y       (in_cell_y),
    .in_cell_blocked (in_cell_blocked),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .sts             (sts)
  );

endmodule

>>> sv/gls_dp.sv
// Datapath: obstacle row memory, line tracer registers and point window test.
module gls_dp
  import gls_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  gls_cmd_t           cmd,
  input  logic [COL_W-1:0]   in_cell_x,
  input  logic [ROW_W-1:0]   in_cell_y,
  input  logic               in_cell_blocked,
  input  logic [5:0]         in_start_x,
  input  logic [5:0]         in_start_y,
  input  logic [5:0]         in_end_x,
  input  logic [5:0]         in_end_y,
  output gls_status_t        sts
);

  logic [MAP_WIDTH-1:0] row_mem [MAP_HEIGHT];
  logic [MAP_HEIGHT-1:0] row_vld_r;
  logic [MAP_WIDTH-1:0] rd_data_r;
  logic                 rd_vld_r;

  logic [COL_W-1:0] wx_r;
  logic [ROW_W-1:0] wy_r;
  logic             wb_r;

  logic signed [7:0] m_r, n_r, m1_r;
  logic [6:0]        dmaj_r, dmin_r;
  logic [7:0]        f_r;
  logic              sm_neg_r, sn_neg_r, swap_r;

  logic signed [7:0] pmaj_r, pmin_r;
  logic [ROW_W-1:0]  rc_r;

  // query setup
  logic signed [7:0] sx2, sy2, ex2, ey2, dx, dy;
  logic [6:0]        adx, ady;
  logic              sw;

  always_comb begin
    sx2 = {1'b0, in_start_x, 1'b0};
    sy2 = {1'b0, in_start_y, 1'b0};
    ex2 = {1'b0, in_end_x, 1'b0};
    ey2 = {1'b0, in_end_y, 1'b0};
    dx  = ex2 - sx2;
    dy  = ey2 - sy2;
    adx = dx[7] ? 7'(-dx) : dx[6:0];
    ady = dy[7] ? 7'(-dy) : dy[6:0];
    sw  = ady > adx;
  end

  logic signed [7:0] om, on, pm_sel, pn_sel;

  always_comb begin
    om = sm_neg_r ? -8'sd1 : 8'sd0;
    on = sn_neg_r ? -8'sd1 : 8'sd0;
    pm_sel = m_r + om;
    case (cmd.pt_sel)
      PH_DIAG, PH_MID: pn_sel = n_r + on;
      PH_AXA:          pn_sel = n_r;
      PH_AXB:          pn_sel = n_r - 8'sd1;
      default:         pn_sel = n_r;
    endcase
  end

  // window bounds of the latched point
  logic signed [7:0] px, py;
  logic [5:0]        hx, hy;
  logic              odx, ody;
  logic signed [7:0] clo, chi, rlo, rhi;
  logic [MAP_WIDTH-1:0] mask;

  always_comb begin
    px = swap_r ? pmin_r : pmaj_r;
    py = swap_r ? pmaj_r : pmin_r;
    hx  = px[7] ? 6'd0 : px[6:1];
    odx = px[7] ? 1'b1 : px[0];
    hy  = py[7] ? 6'd0 : py[6:1];
    ody = py[7] ? 1'b1 : py[0];
    clo = $signed({2'b00, hx}) - 8'sd1;
    chi = $signed({2'b00, hx}) + 8'sd1 + $signed({7'd0, odx});
    rlo = $signed({2'b00, hy}) - 8'sd1;
    rhi = $signed({2'b00, hy}) + 8'sd1 + $signed({7'd0, ody});
    mask = ({MAP_WIDTH{1'b1}} << clo[COL_W-1:0]) &
           ({MAP_WIDTH{1'b1}} >> (COL_W'(MAP_WIDTH - 1) - chi[COL_W-1:0]));
  end

  logic [ROW_W-1:0] rd_addr;
  logic             rd_en;

  always_comb begin
    rd_en   = cmd.wr_rd | cmd.pt_eval | cmd.pt_next;
    rd_addr = wy_r;
    if (cmd.pt_eval) rd_addr = rlo[ROW_W-1:0];
    if (cmd.pt_next) rd_addr = rc_r + ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= row_mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
    if (cmd.wr_wr) begin
      row_mem[wy_r] <= ((rd_vld_r ? rd_data_r : '0) & ~(MAP_WIDTH'(1) << wx_r)) |
                       (MAP_WIDTH'(wb_r) << wx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.wr_wr) begin
      row_vld_r[wy_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      wx_r     <= in_cell_x;
      wy_r     <= in_cell_y;
      wb_r     <= in_cell_blocked;
      m_r      <= sw ? sy2 : sx2;
      n_r      <= sw ? sx2 : sy2;
      m1_r     <= sw ? ey2 : ex2;
      dmaj_r   <= sw ? ady : adx;
      dmin_r   <= sw ? adx : ady;
      sm_neg_r <= sw ? dy[7] : dx[7];
      sn_neg_r <= sw ? dx[7] : dy[7];
      swap_r   <= sw;
      f_r      <= '0;
    end
    if (cmd.f_add) f_r <= f_r + {1'b0, dmin_r};
    if (cmd.adv) begin
      f_r <= f_r - {1'b0, dmaj_r};
      n_r <= sn_neg_r ? n_r - 8'sd2 + 8'sd1 : n_r + 8'sd1;
    end
    if (cmd.move) m_r <= sm_neg_r ? m_r - 8'sd1 : m_r + 8'sd1;
    if (cmd.pt_ld) begin
      pmaj_r <= pm_sel;
      pmin_r <= pn_sel;
    end
    if (cmd.pt_eval) rc_r <= rlo[ROW_W-1:0];
    if (cmd.pt_next) rc_r <= rc_r + ROW_W'(1);
  end

  always_comb begin
    sts.at_end   = m_r == m1_r;
    sts.f_ge     = f_r >= {1'b0, dmaj_r};
    sts.f_nz     = f_r != '0;
    sts.dmin_z   = dmin_r == '0;
    sts.pt_off   = clo < 8'sd0 || chi > 8'(MAP_WIDTH - 1) ||
                   rlo < 8'sd0 || rhi > 8'(MAP_HEIGHT - 1);
    sts.row_hit  = rd_vld_r && ((rd_data_r & mask) != '0);
    sts.row_last = rc_r == rhi[ROW_W-1:0];
  end

endmodule

>>> sv/gls_ctrl.sv
// Controller: sequences map writes, line steps and per-point row scans.
module gls_ctrl
  import gls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_command,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sight_clear,
  input  gls_status_t sts,
  output gls_cmd_t    cmd
);

  gls_state_t state_r, state_nxt;
  gls_phase_t ph_r, ph_nxt;
  logic       res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_clear_r, out_clear_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_DIAG;
      res_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_clear_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
      out_clear_r <= out_clear_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_clear_nxt = out_clear_r;
    cmd           = '0;
    cmd.pt_sel    = ph_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = in_command ? ST_STEP : ST_WR_RD;
        end
      end
      ST_WR_RD: begin
        cmd.wr_rd = 1'b1;
        state_nxt = ST_WR_WR;
      end
      ST_WR_WR: begin
        cmd.wr_wr = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_STEP: begin
        if (sts.at_end) begin
          res_nxt   = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          cmd.f_add = 1'b1;
          state_nxt = ST_DIAG;
        end
      end
      ST_DIAG: begin
        if (sts.f_ge) begin
          ph_nxt    = PH_DIAG;
          state_nxt = ST_PT_LD;
        end else begin
          state_nxt = ST_MID;
        end
      end
      ST_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = ST_MID;
      end
      ST_MID: begin
        if (sts.f_nz) begin
          ph_nxt    = PH_MID;
          state_nxt = ST_PT_LD;
        end else begin
          state_nxt = ST_AXIS;
        end
      end
      ST_AXIS: begin
        if (sts.dmin_z) begin
          ph_nxt    = PH_AXA;
          state_nxt = ST_PT_LD;
        end else begin
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_PT_LD: begin
        cmd.pt_ld = 1'b1;
        state_nxt = ST_PT_EVAL;
      end
      ST_PT_EVAL, ST_PT_CHK: begin
        logic blocked, done;
        blocked = (state_r == ST_PT_EVAL) ? sts.pt_off : sts.row_hit;
        done    = blocked || (state_r == ST_PT_CHK && sts.row_last);
        if (!done) begin
          if (state_r == ST_PT_EVAL) cmd.pt_eval = 1'b1;
          else                       cmd.pt_next = 1'b1;
          state_nxt = ST_PT_CHK;
        end else if (blocked) begin
          case (ph_r)
            PH_AXA: begin
              ph_nxt    = PH_AXB;
              state_nxt = ST_PT_LD;
            end
            default: begin
              res_nxt   = 1'b0;
              state_nxt = ST_RESULT;
            end
          endcase
        end else begin
          case (ph_r)
            PH_DIAG: state_nxt = ST_ADV;
            PH_MID:  state_nxt = ST_AXIS;
            default: state_nxt = ST_MOVE;
          endcase
        end
      end
      ST_RESULT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_clear_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall        = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_sight_clear = out_clear_r;

endmodule

>>> sv/gls_checker.sv
// Port-level checker for grid_line_of_sight, bound to the top level.
module gls_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_sight_clear
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sight_clear))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after an accepted beat");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat with no item in work");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind grid_line_of_sight gls_checker u_gls_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_sight_clear (out_sight_clear)
);
